>>> hw/rtl/mlst_pkg.sv
// Shared constants, types and saturation helper for the MLP trainer.
`timescale 1ns / 1ps

package mlst_pkg;

    // Hidden layer size and the widths that follow from it.
    localparam int MAX_NEURONS = 16;
    localparam int NIDX_W      = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int CNT_W       = $clog2(MAX_NEURONS + 1);
    localparam int ACC_W       = 32 + CNT_W;

    // Shared multiplier widths.
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;
    localparam int RND_W  = PROD_W - 16;

    // Fixed-point constants.
    localparam logic signed [OP_W-1:0] TENTH_Q16 = 33'sd6554;
    localparam logic signed [OP_W-1:0] GRAD_Q32  = 33'sd8589935;
    localparam logic signed [OP_W-1:0] ONE_Q16   = 33'sd65536;

    // Function codes carried in tuser.
    localparam logic [1:0] FUNC_PREDICT = 2'd0;
    localparam logic [1:0] FUNC_TRAIN   = 2'd1;
    localparam logic [1:0] FUNC_LOAD    = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_NEURON_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_SLOPE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd2;

    typedef struct packed {
        logic                   go;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } mlst_mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] raw;
        logic signed [RND_W-1:0]  rnd;
        logic signed [31:0]       sat;
    } mlst_mul_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/mlst_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mlst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mlst_mul.sv
// Shared signed multiplier with rounding and saturation stage.
`timescale 1ns / 1ps

module mlst_mul
    import mlst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  mlst_mul_req_t req,
    output mlst_mul_rsp_t rsp
);

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     res_valid_reg;
    logic signed [PROD_W-1:0] raw_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [31:0]       sat_reg;
    logic signed [PROD_W-1:0] biased;

    assign prod_next = PROD_W'($signed(req.a)) * PROD_W'($signed(req.b));
    // Round half up, then floor shift by 16.
    assign biased    = prod_reg + 66'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= req.go;
            res_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            prod_reg <= prod_next;
        end
        raw_reg <= prod_reg;
        rnd_reg <= biased[PROD_W-1:16];
        sat_reg <= sat32(PROD_W'($signed(biased[PROD_W-1:16])));
    end

    assign rsp.done = res_valid_reg;
    assign rsp.raw  = raw_reg;
    assign rsp.rnd  = rnd_reg;
    assign rsp.sat  = sat_reg;

endmodule

>>> hw/rtl/mlp_leaky_relu_sgd_trainer.sv
// Top level of the one-hidden-layer leaky-ReLU MLP with SGD training.
// Load and unused function codes need no multiply. Predict time grows with the neurons
// in use and with each negative pre-activation; train adds a second pass over the neurons.
// One item is handled at a time, with every multiply on the single shared multiplier.
// Reset clears the sequencer and output valid and sets the configuration to its defaults; weights stay unset.
`timescale 1ns / 1ps

module mlp_leaky_relu_sgd_trainer
    import mlst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input beat.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: x[19:0], neuron_index[23:20], load_in_weight[55:24],
    //          load_bias[87:56], load_out_weight[119:88]
    input  logic [119:0]          s_tdata,
    // s_tuser: func[1:0]
    input  logic [1:0]            s_tuser,
    // Result beat.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: prediction[31:0], squared_error[63:32]
    output logic [63:0]           m_tdata,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer states. ST_WAIT holds until the shared multiplier returns
    // and then jumps to the state stored in ret_reg.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_WAIT = 5'd1;
    localparam logic [4:0] ST_TGT  = 5'd2;
    localparam logic [4:0] ST_FWD0 = 5'd3;
    localparam logic [4:0] ST_LRD  = 5'd4;
    localparam logic [4:0] ST_LHW  = 5'd5;
    localparam logic [4:0] ST_LPRE = 5'd6;
    localparam logic [4:0] ST_LACT = 5'd7;
    localparam logic [4:0] ST_LUSE = 5'd8;
    localparam logic [4:0] ST_LACC = 5'd9;
    localparam logic [4:0] ST_PRED = 5'd10;
    localparam logic [4:0] ST_DIFF = 5'd11;
    localparam logic [4:0] ST_SQ   = 5'd12;
    localparam logic [4:0] ST_SE   = 5'd13;
    localparam logic [4:0] ST_TRN  = 5'd14;
    localparam logic [4:0] ST_T    = 5'd15;
    localparam logic [4:0] ST_C1   = 5'd16;
    localparam logic [4:0] ST_C2   = 5'd17;
    localparam logic [4:0] ST_LG1  = 5'd18;
    localparam logic [4:0] ST_LG2  = 5'd19;
    localparam logic [4:0] ST_LDW  = 5'd20;
    localparam logic [4:0] ST_LDOW = 5'd21;
    localparam logic [4:0] ST_FIN  = 5'd22;

    // Input field views.
    logic signed [19:0] s_x;
    logic [3:0]         s_neuron_index;
    logic [31:0]        s_load_in_weight;
    logic [31:0]        s_load_bias;
    logic [31:0]        s_load_out_weight;

    assign s_x               = s_tdata[19:0];
    assign s_neuron_index    = s_tdata[23:20];
    assign s_load_in_weight  = s_tdata[55:24];
    assign s_load_bias       = s_tdata[87:56];
    assign s_load_out_weight = s_tdata[119:88];

    // Configuration registers.
    logic [4:0]  neuron_count_reg;
    logic [16:0] leak_slope_reg;
    logic [20:0] learn_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neuron_count_reg <= 5'd12;
            leak_slope_reg   <= 17'd0;
            learn_rate_reg   <= 21'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NEURON_COUNT: neuron_count_reg <= cfg_data[4:0];
                CFG_LEAK_SLOPE:   leak_slope_reg   <= cfg_data[16:0];
                CFG_LEARN_RATE:   learn_rate_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    logic [4:0]              state_reg, state_next;
    logic [4:0]              ret_reg, ret_next;
    logic [1:0]              func_reg, func_next;
    logic signed [19:0]      x_reg, x_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic                    train_reg, train_next;
    logic signed [31:0]      tgt_reg, tgt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0]      pre_reg, pre_next;
    logic signed [31:0]      act_reg, act_next;
    logic signed [31:0]      pred_reg, pred_next;
    logic signed [32:0]      diff_reg, diff_next;
    logic [31:0]             se_reg, se_next;
    logic signed [36:0]      t_reg, t_next;
    logic [39:0]             lo_reg, lo_next;
    logic signed [31:0]      common_reg, common_next;
    logic signed [31:0]      g_reg, g_next;
    logic signed [31:0]      dw_reg, dw_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [31:0]      out_pred_reg, out_pred_next;
    logic [31:0]             out_se_reg, out_se_next;

    // Shared multiplier.
    mlst_mul_req_t mul_req;
    mlst_mul_rsp_t mul_rsp;

    mlst_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Weight memories: one write and one read port each.
    logic              ram_we;
    logic [NIDX_W-1:0] ram_waddr;
    logic [31:0]       hw_wdata, hb_wdata, ow_wdata;
    logic [31:0]       hw_rdata, hb_rdata, ow_rdata;
    logic [NIDX_W-1:0] ram_raddr;

    assign ram_raddr = i_reg[NIDX_W-1:0];

    mlst_ram #(.WIDTH(32), .DEPTH(MAX_NEURONS)) u_hw_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (hw_wdata),
        .raddr (ram_raddr),
        .rdata (hw_rdata)
    );

    mlst_ram #(.WIDTH(32), .DEPTH(MAX_NEURONS)) u_hb_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (hb_wdata),
        .raddr (ram_raddr),
        .rdata (hb_rdata)
    );

    mlst_ram #(.WIDTH(32), .DEPTH(MAX_NEURONS)) u_ow_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ow_wdata),
        .raddr (ram_raddr),
        .rdata (ow_rdata)
    );

    // Neurons in use, with counts above the layer size clamped.
    logic [CNT_W-1:0] n_clamped;
    assign n_clamped = (32'(neuron_count_reg) > 32'(MAX_NEURONS)) ?
                       CNT_W'(MAX_NEURONS) : CNT_W'(neuron_count_reg);

    logic                     load_in_range;
    logic signed [31:0]       pre_val;
    logic signed [PROD_W-1:0] common_sum;
    logic [CNT_W-1:0]         i_inc;
    logic                     big_diff;

    assign load_in_range = 32'(s_neuron_index) < 32'(MAX_NEURONS);
    assign pre_val       = sat32(PROD_W'($signed(mul_rsp.sat)) + PROD_W'($signed(hb_rdata)));
    // t*GRAD is rebuilt from the high and low halves of t, then rounded by 2^32.
    assign common_sum    = ($signed(mul_rsp.raw) <<< 16) + PROD_W'(lo_reg)
                           + 66'sd2147483648;
    assign i_inc         = i_reg + 1'b1;
    // Squared error saturates once |d| reaches 2^24.
    assign big_diff      = (diff_reg >= 33'sd16777216) || (diff_reg <= -33'sd16777216);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        func_next      = func_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        train_next     = train_reg;
        tgt_next       = tgt_reg;
        acc_next       = acc_reg;
        pre_next       = pre_reg;
        act_next       = act_reg;
        pred_next      = pred_reg;
        diff_next      = diff_reg;
        se_next        = se_reg;
        t_next         = t_reg;
        lo_next        = lo_reg;
        common_next    = common_reg;
        g_next         = g_reg;
        dw_next        = dw_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_pred_next  = out_pred_reg;
        out_se_next    = out_se_reg;
        mul_req.go     = 1'b0;
        mul_req.a      = '0;
        mul_req.b      = '0;
        ram_we         = 1'b0;
        ram_waddr      = i_reg[NIDX_W-1:0];
        hw_wdata       = sat32(PROD_W'($signed(hw_rdata)) - PROD_W'(dw_reg));
        hb_wdata       = sat32(PROD_W'($signed(hb_rdata)) - PROD_W'(g_reg));
        ow_wdata       = sat32(PROD_W'($signed(ow_rdata)) - PROD_W'($signed(mul_rsp.sat)));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = s_tuser;
                    x_next    = s_x;
                    n_next    = n_clamped;
                    pred_next = '0;
                    se_next   = '0;
                    if (s_tuser == FUNC_LOAD)
                    begin
                        ram_we     = load_in_range;
                        ram_waddr  = NIDX_W'(s_neuron_index);
                        hw_wdata   = s_load_in_weight;
                        hb_wdata   = s_load_bias;
                        ow_wdata   = s_load_out_weight;
                        state_next = ST_FIN;
                    end
                    else if (s_tuser == FUNC_PREDICT || s_tuser == FUNC_TRAIN)
                    begin
                        mul_req.go = 1'b1;
                        mul_req.a  = OP_W'(s_x);
                        mul_req.b  = OP_W'(s_x);
                        ret_next   = ST_TGT;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_TGT:
            begin
                mul_req.go = 1'b1;
                mul_req.a  = OP_W'($signed(mul_rsp.sat));
                mul_req.b  = TENTH_Q16;
                ret_next   = ST_FWD0;
                state_next = ST_WAIT;
            end
            ST_FWD0:
            begin
                tgt_next   = mul_rsp.sat;
                acc_next   = '0;
                i_next     = '0;
                train_next = 1'b0;
                state_next = (n_reg == '0) ? ST_PRED : ST_LRD;
            end
            ST_LRD:
            begin
                state_next = ST_LHW;
            end
            ST_LHW:
            begin
                mul_req.go = 1'b1;
                mul_req.a  = OP_W'($signed(hw_rdata));
                mul_req.b  = OP_W'(x_reg);
                ret_next   = ST_LPRE;
                state_next = ST_WAIT;
            end
            ST_LPRE:
            begin
                pre_next = pre_val;
                if (pre_val < 0)
                begin
                    mul_req.go = 1'b1;
                    mul_req.a  = OP_W'(leak_slope_reg);
                    mul_req.b  = OP_W'(pre_val);
                    ret_next   = ST_LACT;
                    state_next = ST_WAIT;
                end
                else
                begin
                    act_next   = pre_val;
                    state_next = ST_LUSE;
                end
            end
            ST_LACT:
            begin
                act_next   = mul_rsp.sat;
                state_next = ST_LUSE;
            end
            ST_LUSE:
            begin
                mul_req.go = 1'b1;
                if (train_reg)
                begin
                    mul_req.a = OP_W'(common_reg);
                    mul_req.b = OP_W'($signed(ow_rdata));
                    ret_next  = ST_LG1;
                end
                else
                begin
                    mul_req.a = OP_W'($signed(ow_rdata));
                    mul_req.b = OP_W'(act_reg);
                    ret_next  = ST_LACC;
                end
                state_next = ST_WAIT;
            end
            ST_LACC:
            begin
                acc_next   = acc_reg + ACC_W'($signed(mul_rsp.sat));
                i_next     = i_inc;
                state_next = (i_inc == n_reg) ? ST_PRED : ST_LRD;
            end
            ST_PRED:
            begin
                pred_next  = sat32(PROD_W'(acc_reg));
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                diff_next  = 33'(pred_reg) - 33'(tgt_reg);
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (big_diff)
                begin
                    se_next    = 32'hFFFF_FFFF;
                    state_next = ST_TRN;
                end
                else
                begin
                    mul_req.go = 1'b1;
                    mul_req.a  = diff_reg;
                    mul_req.b  = diff_reg;
                    ret_next   = ST_SE;
                    state_next = ST_WAIT;
                end
            end
            ST_SE:
            begin
                se_next    = mul_rsp.rnd[31:0];
                state_next = ST_TRN;
            end
            ST_TRN:
            begin
                if (func_reg == FUNC_TRAIN)
                begin
                    mul_req.go = 1'b1;
                    mul_req.a  = OP_W'(sat32(PROD_W'(diff_reg)));
                    mul_req.b  = OP_W'(learn_rate_reg);
                    ret_next   = ST_T;
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_T:
            begin
                t_next     = mul_rsp.rnd[36:0];
                mul_req.go = 1'b1;
                mul_req.a  = OP_W'(mul_rsp.rnd[15:0]);
                mul_req.b  = GRAD_Q32;
                ret_next   = ST_C1;
                state_next = ST_WAIT;
            end
            ST_C1:
            begin
                lo_next    = mul_rsp.raw[39:0];
                mul_req.go = 1'b1;
                mul_req.a  = OP_W'($signed(t_reg[36:16]));
                mul_req.b  = GRAD_Q32;
                ret_next   = ST_C2;
                state_next = ST_WAIT;
            end
            ST_C2:
            begin
                common_next = sat32(common_sum >>> 32);
                i_next      = '0;
                train_next  = 1'b1;
                state_next  = (n_reg == '0) ? ST_FIN : ST_LRD;
            end
            ST_LG1:
            begin
                mul_req.go = 1'b1;
                mul_req.a  = OP_W'($signed(mul_rsp.sat));
                mul_req.b  = (pre_reg < 0) ? OP_W'(leak_slope_reg) : ONE_Q16;
                ret_next   = ST_LG2;
                state_next = ST_WAIT;
            end
            ST_LG2:
            begin
                g_next     = mul_rsp.sat;
                mul_req.go = 1'b1;
                mul_req.a  = OP_W'($signed(mul_rsp.sat));
                mul_req.b  = OP_W'(x_reg);
                ret_next   = ST_LDW;
                state_next = ST_WAIT;
            end
            ST_LDW:
            begin
                dw_next    = mul_rsp.sat;
                mul_req.go = 1'b1;
                mul_req.a  = OP_W'(common_reg);
                mul_req.b  = OP_W'(act_reg);
                ret_next   = ST_LDOW;
                state_next = ST_WAIT;
            end
            ST_LDOW:
            begin
                // All three weights of this neuron are written from their old values.
                ram_we     = 1'b1;
                i_next     = i_inc;
                state_next = (i_inc == n_reg) ? ST_FIN : ST_LRD;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_pred_next  = pred_reg;
                    out_se_next    = se_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            train_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            train_reg     <= train_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        x_reg        <= x_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        tgt_reg      <= tgt_next;
        acc_reg      <= acc_next;
        pre_reg      <= pre_next;
        act_reg      <= act_next;
        pred_reg     <= pred_next;
        diff_reg     <= diff_next;
        se_reg       <= se_next;
        t_reg        <= t_next;
        lo_reg       <= lo_next;
        common_reg   <= common_next;
        g_reg        <= g_next;
        dw_reg       <= dw_next;
        out_pred_reg <= out_pred_next;
        out_se_reg   <= out_se_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_se_reg, out_pred_reg};

endmodule

>>> hw/rtl/mlst_chk.sv
// Port-level checker for the MLP trainer, bound to the top level.
`timescale 1ns / 1ps

module mlst_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // Items accepted whose result beat has not yet been taken.
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input taken again straight after an accepted beat");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result beat shown with no item outstanding");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> pending_reg == 2'd0 || pending_reg == 2'd1)
        else $error("input accepted with more than one result outstanding");

endmodule

bind mlp_leaky_relu_sgd_trainer mlst_chk u_mlst_chk (.*);

>>> verif/mlp_leaky_relu_sgd_trainer_tb.sv
// Self-checking testbench for the leaky-ReLU MLP trainer: bit-exact network mirror plus stream drivers.
`timescale 1ns / 1ps

// Fixed-point constants of the network: the target scale (0.1) and the gradient scale (0.002).
localparam longint TARGET_TENTH_Q16 = 64'sd6554;
localparam longint GRAD_SCALE_Q32   = 64'sd8589935;

typedef struct {
    logic signed [31:0] prediction;
    logic        [31:0] squared_error;
} trainer_result_t;

// Mirror of the network held by the block. Every accepted input beat is run through the
// same Q16.16 arithmetic here, and the outcome waits in pending_outputs for its result beat.
class trainer_shadow;
    logic signed [31:0] in_weight  [mlst_pkg::MAX_NEURONS];
    logic signed [31:0] bias       [mlst_pkg::MAX_NEURONS];
    logic signed [31:0] out_weight [mlst_pkg::MAX_NEURONS];
    logic        [4:0]  neuron_count;
    logic        [16:0] leak_slope;
    logic        [20:0] learn_rate;
    trainer_result_t    pending_outputs[$];
    int                 mismatches;
    int                 outputs_checked;

    function new();
        neuron_count    = 5'd12;
        leak_slope      = 17'd0;
        learn_rate      = 21'd65536;
        mismatches      = 0;
        outputs_checked = 0;
        foreach (in_weight[i])
        begin
            in_weight[i]  = '0;
            bias[i]       = '0;
            out_weight[i] = '0;
        end
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Round half up, then an arithmetic (floor) shift.
    function longint round_shift(longint v, int s);
        longint r;
        r = v + (longint'(1) << (s - 1));
        return r >>> s;
    endfunction

    function longint qmul(longint a, longint b);
        return sat32(round_shift(a * b, 16));
    endfunction

    function longint pre_activation(int i, longint x);
        return sat32(qmul(longint'(in_weight[i]), x) + longint'(bias[i]));
    endfunction

    function longint leaky(longint pre);
        if (pre < 0)
        begin
            return qmul(longint'(leak_slope), pre);
        end
        return pre;
    endfunction

    function void write_reg(logic [mlst_pkg::CFG_IDX_W-1:0] index,
                            logic [mlst_pkg::CFG_DATA_W-1:0] value);
        case (index)
            mlst_pkg::CFG_NEURON_COUNT: neuron_count = value[4:0];
            mlst_pkg::CFG_LEAK_SLOPE:   leak_slope   = value[16:0];
            mlst_pkg::CFG_LEARN_RATE:   learn_rate   = value[20:0];
            default: ;
        endcase
    endfunction

    function void note_item(logic [1:0] func, logic [119:0] beat);
        trainer_result_t res;
        longint x, acc, pred, target, diff, mag, sq, step, common;
        longint pre, act, slope, g, dw, dow;
        int n;
        logic [3:0] idx;
        res.prediction    = '0;
        res.squared_error = '0;
        x = longint'($signed(beat[19:0]));
        if (func == mlst_pkg::FUNC_LOAD)
        begin
            idx             = beat[23:20];
            in_weight[idx]  = beat[55:24];
            bias[idx]       = beat[87:56];
            out_weight[idx] = beat[119:88];
            pending_outputs.push_back(res);
            return;
        end
        if (func != mlst_pkg::FUNC_PREDICT && func != mlst_pkg::FUNC_TRAIN)
        begin
            pending_outputs.push_back(res);
            return;
        end
        // A count above the array size simply means every neuron.
        n = (neuron_count > mlst_pkg::MAX_NEURONS) ? mlst_pkg::MAX_NEURONS : int'(neuron_count);
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            acc += qmul(longint'(out_weight[i]), leaky(pre_activation(i, x)));
        end
        pred   = sat32(acc);
        target = qmul(qmul(x, x), TARGET_TENTH_Q16);
        diff   = pred - target;
        mag    = (diff < 0) ? -diff : diff;
        if (mag >= (longint'(1) << 24))
        begin
            sq = longint'(32'hFFFF_FFFF);
        end
        else
        begin
            sq = (mag * mag + 32768) >>> 16;
            if (sq > longint'(32'hFFFF_FFFF))
            begin
                sq = longint'(32'hFFFF_FFFF);
            end
        end
        res.prediction    = 32'(pred);
        res.squared_error = 32'(sq);
        pending_outputs.push_back(res);
        if (func == mlst_pkg::FUNC_TRAIN)
        begin
            step   = round_shift(sat32(diff) * longint'(learn_rate), 16);
            common = sat32(round_shift(step * GRAD_SCALE_Q32, 32));
            // Each neuron's update reads only its own old weights.
            for (int i = 0; i < n; i++)
            begin
                pre   = pre_activation(i, x);
                act   = leaky(pre);
                slope = (pre < 0) ? longint'(leak_slope) : 64'sd65536;
                g     = qmul(qmul(common, longint'(out_weight[i])), slope);
                dw    = qmul(g, x);
                dow   = qmul(common, act);
                out_weight[i] = 32'(sat32(longint'(out_weight[i]) - dow));
                bias[i]       = 32'(sat32(longint'(bias[i]) - g));
                in_weight[i]  = 32'(sat32(longint'(in_weight[i]) - dw));
            end
        end
    endfunction

    function void check_output(logic [63:0] beat);
        trainer_result_t want;
        logic signed [31:0] got_pred;
        logic        [31:0] got_sq;
        got_pred = beat[31:0];
        got_sq   = beat[63:32];
        if (pending_outputs.size() == 0)
        begin
            mismatches++;
            $display("%0t: result beat with nothing expected, expected none, actual %h",
                     $time, beat);
            return;
        end
        want = pending_outputs.pop_front();
        outputs_checked++;
        if (got_pred !== want.prediction)
        begin
            mismatches++;
            if (mismatches <= 30)
            begin
                $display("%0t: prediction mismatch, expected %0d, actual %0d",
                         $time, want.prediction, got_pred);
            end
        end
        if (got_sq !== want.squared_error)
        begin
            mismatches++;
            if (mismatches <= 30)
            begin
                $display("%0t: squared_error mismatch, expected %0d, actual %0d",
                         $time, want.squared_error, got_sq);
            end
        end
    endfunction
endclass

module mlp_leaky_relu_sgd_trainer_tb;
    import mlst_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 66;
    // Sized from the slowest item (sixteen neurons, all negative, training),
    // the longest receiver stall and the longest sender gap.
    localparam int WATCHDOG_LIMIT  = 5000;
    // Quiet time after the last result.
    localparam int TAIL_CYCLES     = 600;
    // The fourth function code has no meaning to the block.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // s_tdata: x[19:0], neuron_index[23:20], load_in_weight[55:24],
    //          load_bias[87:56], load_out_weight[119:88]
    logic [119:0]          s_tdata   = '0;
    // s_tuser: func[1:0]
    logic [1:0]            s_tuser   = FUNC_PREDICT;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // m_tdata: prediction[31:0], squared_error[63:32]
    logic [63:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_NEURON_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // The receiver walks round a 16-bit ready pattern that each phase picks afresh.
    logic [15:0]           stall_pattern  = 16'hFFFF;
    logic [3:0]            stall_position = '0;
    int                    idle_cycles    = 0;

    int                    predicts_sent  = 0;
    int                    trains_sent    = 0;
    int                    loads_sent     = 0;
    int                    unused_sent    = 0;

    trainer_shadow         shadow = new();

    mlp_leaky_relu_sgd_trainer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: ready follows the phase's pattern.
    always @(posedge clk)
    begin
        m_tready       <= stall_pattern[stall_position];
        stall_position <= stall_position + 4'd1;
    end

    // Every result beat is compared with the oldest outstanding expected result.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            shadow.check_output(m_tdata);
        end
    end

    // Watchdog: a long stretch with no beat on any channel means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [119:0] pack_item(logic [19:0] x, logic [3:0] index,
                                               logic [31:0] w, logic [31:0] b,
                                               logic [31:0] ow);
        return {ow, b, w, index, x};
    endfunction

    // Weights are mostly within about +-1.5 so that training stays meaningful; now and then
    // a full-range word or a saturation extreme goes in.
    function automatic logic [31:0] random_weight();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return $urandom;
        end
        if (pick == 1)
        begin
            return 32'h7FFF_FFFF;
        end
        if (pick == 2)
        begin
            return 32'h8000_0000;
        end
        return 32'($urandom_range(0, 196607)) - 32'd98304;
    endfunction

    // Samples are mostly within +-3.0, and otherwise anywhere in the 20-bit range.
    function automatic logic [19:0] random_x();
        if ($urandom_range(0, 9) < 3)
        begin
            return 20'($urandom);
        end
        return 20'($urandom_range(0, 393215) - 196608);
    endfunction

    // Valid is left high on return; the caller decides whether a gap follows.
    task automatic send_item(input logic [1:0] func, input logic [119:0] beat);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= beat;
        do @(posedge clk); while (!s_tready);
        shadow.note_item(func, beat);
        case (func)
            FUNC_PREDICT: predicts_sent++;
            FUNC_TRAIN:   trains_sent++;
            FUNC_LOAD:    loads_sent++;
            default:      unused_sent++;
        endcase
    endtask

    // Sender stops and waits until every outstanding result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (shadow.pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Writes all three registers back to back; only called with the block idle.
    task automatic apply_settings(input logic [4:0] count, input logic [16:0] slope,
                                  input logic [20:0] rate);
        logic [CFG_IDX_W-1:0]  indexes [3];
        logic [CFG_DATA_W-1:0] values  [3];
        indexes = '{CFG_NEURON_COUNT, CFG_LEAK_SLOPE, CFG_LEARN_RATE};
        values  = '{21'(count), 21'(slope), rate};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= indexes[k];
            cfg_data  <= values[k];
            do @(posedge clk); while (!cfg_ready);
            shadow.write_reg(indexes[k], values[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random traffic in bursts. Unused function codes leave the weights alone and are not
    // counted towards the phase's item total.
    task automatic run_phase(input int items, input bit with_gaps);
        int          burst_left;
        int          sent;
        int unsigned pick;
        logic [1:0]  func;
        burst_left = $urandom_range(1, 12);
        sent       = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                func = FUNC_PREDICT;
            end
            else if (pick < 75)
            begin
                func = FUNC_TRAIN;
            end
            else if (pick < 95)
            begin
                func = FUNC_LOAD;
            end
            else
            begin
                func = FUNC_UNUSED;
            end
            send_item(func, pack_item(random_x(), 4'($urandom), random_weight(),
                                      random_weight(), random_weight()));
            if (func != FUNC_UNUSED)
            begin
                sent++;
            end
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if (with_gaps)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
        end
        drain();
    endtask

    initial
    begin
        logic [4:0]  counts [5];
        logic [16:0] slopes [5];
        logic [20:0] rates  [5];
        logic [4:0]  count;
        logic [16:0] slope;
        logic [20:0] rate;
        logic [19:0] directed_x [5];
        logic [19:0] train_x    [3];

        // Fixed settings first: the full array at unit slope, a single neuron with
        // learning switched off, no neurons at all, an over-large count with the
        // steepest slope and the largest rate the fields hold, then a middle setting.
        counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8};
        slopes = '{17'd65536, 17'd0, 17'd32768, 17'd131071, 17'd6554};
        rates  = '{21'd65536, 21'd0, 21'd65536, 21'd2097151, 21'd1048576};

        directed_x = '{20'h00000, 20'h7FFFF, 20'h80000, 20'hFFFFF, 20'h10000};
        train_x    = '{20'h7FFFF, 20'h80000, 20'h18000};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset settings (twelve neurons, zero slope, unit rate).
        // Every neuron is loaded before anything reads it; the top two carry the
        // saturation extremes so that later phases using all sixteen neurons hit them.
        for (int i = 0; i < MAX_NEURONS - 2; i++)
        begin
            send_item(FUNC_LOAD, pack_item(20'h00000, 4'(i), random_weight(),
                                           random_weight(), random_weight()));
        end
        send_item(FUNC_LOAD, pack_item(20'hFFFFF, 4'd14, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000));
        send_item(FUNC_LOAD, pack_item(20'h00000, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF));
        // Zero, both ends of the sample range, minus one LSB and plus one.
        foreach (directed_x[i])
        begin
            send_item(FUNC_PREDICT, pack_item(directed_x[i], 4'd0, '0, '0, '0));
        end
        foreach (train_x[i])
        begin
            send_item(FUNC_TRAIN, pack_item(train_x[i], 4'd0, '0, '0, '0));
        end
        // The unused function code, with every data bit set, must leave the weights alone.
        send_item(FUNC_UNUSED, '1);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 5)
            begin
                count = counts[phase];
                slope = slopes[phase];
                rate  = rates[phase];
            end
            else
            begin
                count = 5'($urandom_range(1, 16));
                slope = 17'($urandom_range(0, 131071));
                rate  = 21'($urandom_range(0, 1048576));
            end
            // Two phases take every result at once; the rest stall at random.
            if (phase == 1 || phase == 6)
            begin
                stall_pattern <= 16'hFFFF;
            end
            else
            begin
                stall_pattern <= 16'($urandom) | 16'h0001;
            end
            apply_settings(count, slope, rate);
            // Phases two and five keep the sender streaming without gaps.
            run_phase(ITEMS_PER_PHASE, (phase != 2) && (phase != 5));
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d predict, %0d train, %0d load and %0d unused-code beats",
                 predicts_sent, trains_sent, loads_sent, unused_sent);
        $display("across %0d register settings; %0d results compared, %0d mismatches.",
                 PHASES + 1, shadow.outputs_checked, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending_outputs.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            if (shadow.pending_outputs.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived", $time,
                         shadow.pending_outputs.size());
            end
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mlst_pkg.sv
hw/rtl/mlst_ram.sv
hw/rtl/mlst_mul.sv
hw/rtl/mlp_leaky_relu_sgd_trainer.sv
hw/rtl/mlst_chk.sv
verif/mlp_leaky_relu_sgd_trainer_tb.sv
